[hdl/c2pa_pkg.sv]
// ----------------------------------------------------------------------------
// c2pa_pkg: shared types and constants of the cell-to-point average engine
// Store geometry, field widths, state codes and the lane command structure.
// ----------------------------------------------------------------------------
package c2pa_pkg;

	localparam int DEPTH     = 1024;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int NUM_COMP  = 3;
	localparam int VAL_W     = 32;
	localparam int SUM_W     = 40;
	localparam int CNT_W     = 8;
	localparam int PCNT_W    = 11;
	localparam int STEP_W    = $clog2(SUM_W + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;

	localparam logic OP_ACC  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic REG_POINT_COUNT = 1'b0;

	typedef struct packed {
		logic              we;
		logic              add;
		logic [ADDR_W-1:0] addr;
		logic              start;
		logic              step;
	} lane_cmd_t;

endpackage

[hdl/c2pa_lane.sv]
// ----------------------------------------------------------------------------
// c2pa_lane: one component lane
// Holds the running sums of one component and a bit-serial signed divider.
// ----------------------------------------------------------------------------
module c2pa_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  c2pa_pkg::lane_cmd_t                   cmd,
	input  logic signed [c2pa_pkg::VAL_W-1:0]     value,
	input  logic        [c2pa_pkg::CNT_W-1:0]     divisor,
	output logic signed [c2pa_pkg::SUM_W-1:0]     result
);

	logic [c2pa_pkg::SUM_W-1:0] mem [c2pa_pkg::DEPTH];
	logic [c2pa_pkg::SUM_W-1:0] rd_q;
	logic [c2pa_pkg::SUM_W-1:0] wdata;
	logic [c2pa_pkg::SUM_W-1:0] raw_q;
	logic [c2pa_pkg::SUM_W-1:0] quo_q;
	logic [c2pa_pkg::CNT_W-1:0] rem_q;
	logic                       neg_q;
	logic [c2pa_pkg::CNT_W:0]   trial;
	logic                       ge;

	assign wdata = cmd.add
		? rd_q + {{(c2pa_pkg::SUM_W-c2pa_pkg::VAL_W){value[c2pa_pkg::VAL_W-1]}}, value}
		: '0;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.addr] <= wdata;
		end
		rd_q <= mem[cmd.addr];
	end

	assign trial = {rem_q, quo_q[c2pa_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
		end else if (cmd.start) begin
			neg_q <= rd_q[c2pa_pkg::SUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			raw_q <= rd_q;
			quo_q <= rd_q[c2pa_pkg::SUM_W-1] ? (~rd_q + 1'b1) : rd_q;
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? c2pa_pkg::CNT_W'(trial - {1'b0, divisor})
			            : trial[c2pa_pkg::CNT_W-1:0];
			quo_q <= {quo_q[c2pa_pkg::SUM_W-2:0], ge};
		end
	end

	always_comb begin
		if (divisor == '0) begin
			result = raw_q;
		end else if (neg_q) begin
			result = ~quo_q + 1'b1;
		end else begin
			result = quo_q;
		end
	end

endmodule

[hdl/cell_to_point_average.sv]
// ----------------------------------------------------------------------------
// cell_to_point_average: scatter-average engine from cell values to points
// Accumulates per-point sums and counts and returns truncated averages.
// ----------------------------------------------------------------------------
// Items enter on the s_ group: s_tuser is the opcode (accumulate or read),
// s_tdata carries the point index and three Q16.16 components. Results leave
// on the m_ group: m_tdata carries three 40-bit averages and the saturated
// contributor count, m_tuser flags an index at or beyond point_count.
// An accumulate item gives no result. A read item runs through the per-lane
// bit-serial divider, one quotient bit per cycle over 40 bits, and clears
// the point. An out-of-range index returns a flagged item with zero data and
// leaves the store unchanged. An in-range item reads the point from the store
// memory port and then writes it back through the same port.
// After reset a clearing pass zeroes all 1024 points, one per cycle, and
// s_tready stays low until the pass is done. point_count resets to 1024.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result holds in the engine until the register frees.
// point_count is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module cell_to_point_average (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // point_index, value_c0, value_c1, value_c2, zero pad
	input  logic [0:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // average_c0, average_c1, average_c2, contributor_count
	output logic [0:0]   m_tuser,   // index_error
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = c2pa_pkg::ADDR_W;
	localparam int SW = c2pa_pkg::SUM_W;
	localparam int VW = c2pa_pkg::VAL_W;
	localparam int CW = c2pa_pkg::CNT_W;
	localparam int NC = c2pa_pkg::NUM_COMP;

	logic [2:0]                      state_q;
	logic [AW-1:0]                   clr_q;
	logic [c2pa_pkg::STEP_W-1:0]     step_q;
	logic [c2pa_pkg::PCNT_W-1:0]     point_count_q;
	logic                            op_q;
	logic                            err_q;
	logic [AW-1:0]                   idx_q;
	logic [NC*VW-1:0]                val_q;
	logic [CW-1:0]                   cnt_q;
	logic [CW-1:0]                   cnt_rd_q;
	logic [CW-1:0]                   cnt_mem [c2pa_pkg::DEPTH];
	logic                            cnt_we;
	logic [CW-1:0]                   cnt_wdata;
	logic                            accept;
	logic                            cfg_wr;
	logic                            out_free;
	c2pa_pkg::lane_cmd_t             cmd;
	logic [NC*SW-1:0]                res;
	logic [127:0]                    m_data_q;
	logic                            m_err_q;
	logic                            m_valid_q;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == c2pa_pkg::REG_POINT_COUNT);
	assign prdata   = (paddr[2] == c2pa_pkg::REG_POINT_COUNT)
		? {{(32-c2pa_pkg::PCNT_W){1'b0}}, point_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= c2pa_pkg::PCNT_W'(c2pa_pkg::DEPTH);
		end else if (cfg_wr) begin
			point_count_q <= pwdata[c2pa_pkg::PCNT_W-1:0];
		end
	end

	assign s_tready = (state_q == c2pa_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		cmd       = '0;
		cnt_we    = 1'b0;
		cnt_wdata = '0;
		case (state_q)
			c2pa_pkg::ST_CLR: begin
				cmd.we   = 1'b1;
				cmd.addr = clr_q;
				cnt_we   = 1'b1;
			end
			c2pa_pkg::ST_IDLE: begin
				cmd.addr = s_tdata[AW-1:0];
			end
			c2pa_pkg::ST_LOOK: begin
				cmd.addr = idx_q;
				if (!err_q) begin
					cmd.we = 1'b1;
					cnt_we = 1'b1;
					if (op_q == c2pa_pkg::OP_ACC) begin
						cmd.add   = 1'b1;
						cnt_wdata = (cnt_rd_q == c2pa_pkg::CNT_MAX) ? cnt_rd_q
						                                            : cnt_rd_q + 1'b1;
					end else begin
						cmd.start = 1'b1;
					end
				end
			end
			c2pa_pkg::ST_DIV: begin
				cmd.addr = idx_q;
				cmd.step = 1'b1;
			end
			default: begin
				cmd.addr = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cmd.addr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cmd.addr];
	end

	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_lane
			c2pa_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.value   (val_q[g*VW +: VW]),
				.divisor (cnt_q),
				.result  (res[g*SW +: SW])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser[0];
			idx_q <= s_tdata[AW-1:0];
			val_q <= s_tdata[AW +: NC*VW];
			err_q <= {1'b0, s_tdata[AW-1:0]} >= point_count_q;
		end
		if (state_q == c2pa_pkg::ST_LOOK) begin
			cnt_q <= cnt_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c2pa_pkg::ST_CLR;
			clr_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				c2pa_pkg::ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(c2pa_pkg::DEPTH - 1)) begin
						state_q <= c2pa_pkg::ST_IDLE;
					end
				end
				c2pa_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= c2pa_pkg::ST_LOOK;
					end
				end
				c2pa_pkg::ST_LOOK: begin
					step_q <= '0;
					if (err_q) begin
						state_q <= c2pa_pkg::ST_PUT;
					end else if (op_q == c2pa_pkg::OP_ACC) begin
						state_q <= c2pa_pkg::ST_IDLE;
					end else begin
						state_q <= c2pa_pkg::ST_DIV;
					end
				end
				c2pa_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == c2pa_pkg::STEP_W'(SW - 1)) begin
						state_q <= c2pa_pkg::ST_PUT;
					end
				end
				c2pa_pkg::ST_PUT: begin
					if (out_free) begin
						state_q <= c2pa_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= c2pa_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == c2pa_pkg::ST_PUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == c2pa_pkg::ST_PUT && out_free) begin
			m_err_q  <= err_q;
			m_data_q <= err_q ? '0 : {cnt_q, res};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_err_q;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cell-to-point average engine
// Drives accumulate and read items on the input stream, keeps its own copy
// of the per-point sums and counts to predict each average, and compares
// every result on the output stream. Covers index limits, rounding toward
// zero, count saturation, sum wrap, point_count settings and backpressure.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH  = c2pa_pkg::DEPTH;
	localparam int ADDR_W = c2pa_pkg::ADDR_W;
	localparam int VAL_W  = c2pa_pkg::VAL_W;
	localparam int SUM_W  = c2pa_pkg::SUM_W;
	localparam int CNT_W  = c2pa_pkg::CNT_W;
	localparam int PCNT_W = c2pa_pkg::PCNT_W;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE = 60;

	typedef struct {
		logic [SUM_W-1:0] avg0;
		logic [SUM_W-1:0] avg1;
		logic [SUM_W-1:0] avg2;
		logic [CNT_W-1:0] cnt;
		logic             err;
	} average_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;   // point_index, value_c0, value_c1, value_c2, zero pad
	logic [0:0]   s_tuser = '0;   // opcode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // average_c0, average_c1, average_c2, contributor_count
	logic [0:0]   m_tuser;        // index_error
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	logic [SUM_W-1:0] sum_c0 [DEPTH];
	logic [SUM_W-1:0] sum_c1 [DEPTH];
	logic [SUM_W-1:0] sum_c2 [DEPTH];
	logic [CNT_W-1:0] hits [DEPTH];
	logic [PCNT_W-1:0] points_in_use;
	average_t pending_averages [$];

	int  mismatches = 0;
	int  failures = 0;
	int  cycles = 0;
	int  results_seen = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;

	cell_to_point_average uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always begin
		@(posedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (300) @(posedge clk);
			hold_req = 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [SUM_W-1:0] divide_sum(logic [SUM_W-1:0] s, logic [CNT_W-1:0] n);
		longint sv;
		longint q;
		if (n == 0) return s;
		sv = longint'($signed(s));
		q = sv / longint'(n);
		return q[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] widen(logic [VAL_W-1:0] v);
		return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	task automatic apply_point_item(logic op, logic [ADDR_W-1:0] idx,
			logic [VAL_W-1:0] v0, logic [VAL_W-1:0] v1, logic [VAL_W-1:0] v2);
		average_t r;
		r = '{default: '0};
		if (idx >= points_in_use || idx >= DEPTH) begin
			r.err = 1'b1;
			pending_averages.push_back(r);
		end else if (op == c2pa_pkg::OP_ACC) begin
			sum_c0[idx] = sum_c0[idx] + widen(v0);
			sum_c1[idx] = sum_c1[idx] + widen(v1);
			sum_c2[idx] = sum_c2[idx] + widen(v2);
			if (hits[idx] != c2pa_pkg::CNT_MAX) hits[idx] = hits[idx] + 1'b1;
		end else begin
			r.avg0 = divide_sum(sum_c0[idx], hits[idx]);
			r.avg1 = divide_sum(sum_c1[idx], hits[idx]);
			r.avg2 = divide_sum(sum_c2[idx], hits[idx]);
			r.cnt = hits[idx];
			sum_c0[idx] = '0;
			sum_c1[idx] = '0;
			sum_c2[idx] = '0;
			hits[idx] = '0;
			pending_averages.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		average_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (pending_averages.size() == 0) begin
				failures++;
				$display("Unexpected result item: %h err %b", m_tdata, m_tuser);
			end else begin
				want = pending_averages.pop_front();
				if (m_tdata[39:0] !== want.avg0 || m_tdata[79:40] !== want.avg1 ||
						m_tdata[119:80] !== want.avg2 || m_tdata[127:120] !== want.cnt ||
						m_tuser[0] !== want.err) begin
					failures++;
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %h %h %h cnt %0d err %b, got %h %h %h cnt %0d err %b",
							want.avg0, want.avg1, want.avg2, want.cnt, want.err,
							m_tdata[39:0], m_tdata[79:40], m_tdata[119:80],
							m_tdata[127:120], m_tuser[0]);
				end
			end
		end
	end

	task automatic send_item(logic op, logic [ADDR_W-1:0] idx,
			logic [VAL_W-1:0] v0, logic [VAL_W-1:0] v1, logic [VAL_W-1:0] v2);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, v2, v1, v0, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_point_item(op, idx, v0, v1, v2);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_point_count(logic [PCNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {c2pa_pkg::REG_POINT_COUNT, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		points_in_use = value;
	endtask

	task automatic test_reset_state();
		send_item(c2pa_pkg::OP_READ, 0, 0, 0, 0);
		send_item(c2pa_pkg::OP_READ, 1023, 32'hFFFF_FFFF, 0, 0);
		wait_drained();
	endtask

	task automatic test_directed();
		send_item(c2pa_pkg::OP_ACC, 5, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_item(c2pa_pkg::OP_ACC, 5, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_item(c2pa_pkg::OP_READ, 5, 0, 0, 0);
		send_item(c2pa_pkg::OP_READ, 5, 0, 0, 0);
		send_item(c2pa_pkg::OP_ACC, 1023, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA);
		send_item(c2pa_pkg::OP_READ, 1023, 0, 0, 0);
		send_item(c2pa_pkg::OP_ACC, 9, -32'sd7, 32'sd7, -32'sd1);
		send_item(c2pa_pkg::OP_ACC, 9, -32'sd7, 32'sd7, -32'sd1);
		send_item(c2pa_pkg::OP_ACC, 9, 0, 0, 0);
		send_item(c2pa_pkg::OP_READ, 9, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_saturation_and_wrap();
		for (int i = 0; i < 300; i++)
			send_item(c2pa_pkg::OP_ACC, 2, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		send_item(c2pa_pkg::OP_READ, 2, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_point_count();
		write_point_count(1);
		send_item(c2pa_pkg::OP_ACC, 0, 32'h1234_5678, 3, 32'h8000_0001);
		send_item(c2pa_pkg::OP_ACC, 1, 5, 5, 5);
		send_item(c2pa_pkg::OP_READ, 1, 0, 0, 0);
		send_item(c2pa_pkg::OP_READ, 0, 0, 0, 0);
		wait_drained();
		write_point_count(0);
		send_item(c2pa_pkg::OP_ACC, 0, 1, 1, 1);
		send_item(c2pa_pkg::OP_READ, 0, 0, 0, 0);
		wait_drained();
		write_point_count(11'd1500);
		send_item(c2pa_pkg::OP_ACC, 1023, 9, -32'sd9, 4);
		send_item(c2pa_pkg::OP_READ, 1023, 0, 0, 0);
		wait_drained();
		write_point_count(11'd1024);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random(int items, logic [PCNT_W-1:0] pc);
		logic [ADDR_W-1:0] idx;
		int window;
		wait_drained();
		write_point_count(pc);
		window = (pc > 16) ? 16 : pc + 2;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 9) == 0) idx = ADDR_W'($urandom);
			else idx = ADDR_W'($urandom_range(0, window - 1));
			send_item(($urandom_range(0, 9) < 3) ? c2pa_pkg::OP_READ : c2pa_pkg::OP_ACC, idx,
				pick_value(), pick_value(), pick_value());
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			send_item(c2pa_pkg::OP_READ, ADDR_W'($urandom_range(0, 15)),
				$urandom, $urandom, $urandom);
		wait_drained();
		for (int i = 0; i < 10; i++)
			send_item(c2pa_pkg::OP_ACC, 3, $urandom, $urandom, $urandom);
		send_item(c2pa_pkg::OP_READ, 3, 0, 0, 0);
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			sum_c0[i] = '0;
			sum_c1[i] = '0;
			sum_c2[i] = '0;
			hits[i] = '0;
		end
		points_in_use = 11'd1024;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_saturation_and_wrap();
		test_point_count();
		test_backpressure();
		test_random(350, 11'd1024);
		test_random(300, PCNT_W'($urandom_range(2, 1023)));
		test_random(150, 11'd1);
		test_random(350, PCNT_W'($urandom_range(17, 1023)));
		quiet = 1'b1;
		test_random(300, 11'd1024);
		$display("Covered accumulate and read items, index limits, count saturation, sum wrap,");
		$display("point_count settings and long output stalls; %0d result items checked.",
			results_seen);
		if (failures == 0 && pending_averages.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
